// ===== rtl/fht_pkg.sv =====
// Shared types, constants and helpers for the flow hash table with aging.
// No dependencies; every other file in rtl/ imports this package.
package fht_pkg;

   // Table geometry; depth must be a power of two
   localparam int TABLE_DEPTH = 1024;
   localparam int KEY_WORDS   = 4;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int WORD_W      = 2;
   localparam int SLOT_W      = 10;
   localparam int LIVE_W      = 11;

   // Word-wise FNV-1a style hash constants
   localparam logic [31:0] HASH_SEED = 32'h811C_9DC5;
   localparam logic [31:0] HASH_MUL  = 32'h0100_0193;

   typedef enum logic [0:0] {
      OP_LOOKUP = 1'b0,
      OP_SWEEP  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_HIT     = 2'd0,
      ST_CREATED = 2'd1,
      ST_FULL    = 2'd2,
      ST_SWEPT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_LIVE  = 2'd1,
      SLOT_TOMB  = 2'd2,
      SLOT_UNDEF = 2'd3
   } slot_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_HASH,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PROBE,
      BK_SWEEP,
      BK_RESP
   } back_state_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [63:0] now_time;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_index;
      logic [63:0]       created_time;
      logic [LIVE_W-1:0] live_entries;
      logic [LIVE_W-1:0] expired_entries;
   } rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      opcode_type       opcode;
      logic [63:0]      key_low;
      logic [63:0]      key_high;
      logic [63:0]      now_time;
      logic [IDX_W-1:0] home;
   } job_type;

   // Keep only the key words that take part in hash and compare
   function automatic logic [63:0] mask_low(input logic [63:0] lo);
      return (KEY_WORDS < 2) ? {32'd0, lo[31:0]} : lo;
   endfunction

   function automatic logic [63:0] mask_high(input logic [63:0] hi);
      logic [63:0] r;
      if (KEY_WORDS < 3)      r = 64'd0;
      else if (KEY_WORDS < 4) r = {32'd0, hi[31:0]};
      else                    r = hi;
      return r;
   endfunction

   function automatic logic [31:0] key_word(input logic [63:0] lo,
                                            input logic [63:0] hi,
                                            input logic [WORD_W-1:0] n);
      logic [31:0] w;
      case (n)
         2'd0:    w = lo[31:0];
         2'd1:    w = lo[63:32];
         2'd2:    w = hi[31:0];
         default: w = hi[63:32];
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/fht_front.sv =====
// Front end: takes request items, hashes the key one word per cycle and
// queues classified jobs for the back end. Depends on fht_pkg.
module fht_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  fht_pkg::req_type req_data,
   output logic             job_valid,
   output fht_pkg::job_type job_data,
   input  logic             job_pop
);
   import fht_pkg::*;

   front_state_type   state_ff, state_in;
   job_type           job_ff, job_in;
   logic [31:0]       hash_ff, hash_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [31:0]       prod;
   logic              q_push;

   // two-entry job queue
   job_type     q_mem_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  qcnt_ff;

   assign req_full = (state_ff != FR_IDLE);

   // one hash round: xor a key word in, multiply, keep 32 bits
   assign prod = (hash_ff ^ key_word(job_ff.key_low, job_ff.key_high, word_ff)) * HASH_MUL;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      hash_in  = hash_ff;
      word_in  = word_ff;
      q_push   = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            if (req_push) begin
               job_in.opcode   = req_data.opcode;
               job_in.key_low  = mask_low(req_data.key_low);
               job_in.key_high = mask_high(req_data.key_high);
               job_in.now_time = req_data.now_time;
               job_in.home     = '0;
               hash_in         = HASH_SEED;
               word_in         = '0;
               state_in = (req_data.opcode == OP_SWEEP) ? FR_PUSH : FR_HASH;
            end
         end
         FR_HASH: begin
            hash_in = prod;
            word_in = word_ff + 1'b1;
            if (word_ff == WORD_W'(KEY_WORDS - 1)) begin
               job_in.home = prod[IDX_W-1:0];
               state_in    = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (qcnt_ff != 2'd2) begin
               q_push   = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff  <= job_in;
      hash_ff <= hash_in;
      word_ff <= word_in;
   end

   // job queue pointers and storage
   assign job_valid = (qcnt_ff != 2'd0);
   assign job_data  = q_mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         qcnt_ff <= 2'd0;
      end else begin
         if (q_push) wp_ff <= ~wp_ff;
         if (job_pop && job_valid) rp_ff <= ~rp_ff;
         qcnt_ff <= qcnt_ff + {1'b0, q_push} - {1'b0, job_pop && job_valid};
      end
      if (q_push) q_mem_ff[wp_ff] <= job_ff;
   end

endmodule

// ===== rtl/fht_back.sv =====
// Back end: slot memories, linear probe, insert, expire sweep, result
// register and the idle timeout register. Depends on fht_pkg.
module fht_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  fht_pkg::job_type job_data,
   output logic             job_pop,
   input  logic             csr_we,
   input  logic [63:0]      csr_wdata,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fht_pkg::rsp_type rsp_data,
   output logic [fht_pkg::CNT_W-1:0] live_count
);
   import fht_pkg::*;

   // slot memories
   slot_type    st_mem  [TABLE_DEPTH];
   logic [63:0] klo_mem [TABLE_DEPTH];
   logic [63:0] khi_mem [TABLE_DEPTH];
   logic [63:0] cre_mem [TABLE_DEPTH];
   logic [63:0] ls_mem  [TABLE_DEPTH];

   slot_type         st_rd_ff;
   logic [63:0]      klo_rd_ff, khi_rd_ff, cre_rd_ff, ls_rd_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             we_st, we_key, we_ls;
   slot_type         wd_st;
   logic [63:0]      wd_ls;

   back_state_type   state_ff, state_in;
   job_type          job_ff, job_in;
   logic [IDX_W-1:0] cur_ff, cur_in, tomb_ff, tomb_in, nxt;
   logic             have_ff, have_in;
   logic [CNT_W-1:0] live_ff, live_in, rem_ff, rem_in;
   logic [63:0]      timeout_ff;
   rsp_type          res_ff, res_in, rsp_ff;
   logic             rsp_valid_ff, push_rsp;
   logic             miss;
   logic [IDX_W-1:0] miss_slot;
   logic [63:0]      age;

   assign nxt        = cur_ff + 1'b1;
   assign age        = job_ff.now_time - ls_rd_ff;
   assign live_count = live_ff;
   assign rsp_empty  = ~rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cur_in    = cur_ff;
      tomb_in   = tomb_ff;
      have_in   = have_ff;
      live_in   = live_ff;
      rem_in    = rem_ff;
      res_in    = res_ff;
      rd_addr   = cur_ff;
      wr_addr   = cur_ff;
      we_st     = 1'b0;
      we_key    = 1'b0;
      we_ls     = 1'b0;
      wd_st     = SLOT_EMPTY;
      wd_ls     = job_ff.now_time;
      job_pop   = 1'b0;
      push_rsp  = 1'b0;
      miss      = 1'b0;
      miss_slot = cur_ff;
      unique case (state_ff)
         // clearing pass over slot states after reset
         BK_CLEAR: begin
            we_st  = 1'b1;
            wd_st  = SLOT_EMPTY;
            cur_in = nxt;
            if (cur_ff == IDX_W'(TABLE_DEPTH - 1)) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in  = job_data;
               have_in = 1'b0;
               rem_in  = '0;
               if (job_data.opcode == OP_SWEEP) begin
                  rd_addr  = '0;
                  cur_in   = '0;
                  state_in = BK_SWEEP;
               end else begin
                  rd_addr  = job_data.home;
                  cur_in   = job_data.home;
                  state_in = BK_PROBE;
               end
            end
         end
         // one probed slot per cycle
         BK_PROBE: begin
            rd_addr = nxt;
            cur_in  = nxt;
            if (st_rd_ff == SLOT_EMPTY) begin
               miss      = 1'b1;
               miss_slot = have_ff ? tomb_ff : cur_ff;
            end else if (st_rd_ff == SLOT_TOMB) begin
               if (!have_ff) begin
                  have_in = 1'b1;
                  tomb_in = cur_ff;
               end
               if (nxt == job_ff.home) begin
                  miss      = 1'b1;
                  miss_slot = have_ff ? tomb_ff : cur_ff;
               end
            end else if (klo_rd_ff == job_ff.key_low && khi_rd_ff == job_ff.key_high) begin
               we_ls                 = 1'b1;
               res_in.status         = ST_HIT;
               res_in.slot_index     = SLOT_W'(cur_ff);
               res_in.created_time   = cre_rd_ff;
               res_in.live_entries   = LIVE_W'(live_ff);
               res_in.expired_entries = '0;
               state_in              = BK_RESP;
            end else if (nxt == job_ff.home) begin
               miss      = 1'b1;
               miss_slot = have_ff ? tomb_ff : nxt;
            end
            if (miss) begin
               state_in               = BK_RESP;
               res_in.expired_entries = '0;
               if (live_ff >= CNT_W'(TABLE_DEPTH)) begin
                  res_in.status       = ST_FULL;
                  res_in.slot_index   = '0;
                  res_in.created_time = '0;
                  res_in.live_entries = LIVE_W'(live_ff);
               end else begin
                  wr_addr             = miss_slot;
                  we_st               = 1'b1;
                  wd_st               = SLOT_LIVE;
                  we_key              = 1'b1;
                  we_ls               = 1'b1;
                  live_in             = live_ff + 1'b1;
                  res_in.status       = ST_CREATED;
                  res_in.slot_index   = SLOT_W'(miss_slot);
                  res_in.created_time = job_ff.now_time;
                  res_in.live_entries = LIVE_W'(live_ff + 1'b1);
               end
            end
         end
         // expire sweep, one slot per cycle
         BK_SWEEP: begin
            rd_addr = nxt;
            cur_in  = nxt;
            if (st_rd_ff == SLOT_LIVE && age > timeout_ff) begin
               we_st  = 1'b1;
               wd_st  = SLOT_TOMB;
               rem_in = rem_ff + 1'b1;
               if (live_ff != '0) live_in = live_ff - 1'b1;
            end
            if (cur_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               res_in.status          = ST_SWEPT;
               res_in.slot_index      = '0;
               res_in.created_time    = '0;
               res_in.live_entries    = LIVE_W'(live_in);
               res_in.expired_entries = LIVE_W'(rem_in);
               state_in               = BK_RESP;
            end
         end
         // hand the result to the output register once it is free
         BK_RESP: begin
            if (!rsp_valid_ff || rsp_pop) begin
               push_rsp = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         cur_ff       <= '0;
         live_ff      <= '0;
         timeout_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         live_ff      <= live_in;
         if (csr_we) timeout_ff <= csr_wdata;
         rsp_valid_ff <= push_rsp | (rsp_valid_ff & ~rsp_pop);
      end
      job_ff  <= job_in;
      tomb_ff <= tomb_in;
      have_ff <= have_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      if (push_rsp) rsp_ff <= res_ff;
   end

   // memory ports: one write, one registered read each
   always_ff @(posedge clock) begin
      if (we_st) st_mem[wr_addr] <= wd_st;
      if (we_key) begin
         klo_mem[wr_addr] <= job_ff.key_low;
         khi_mem[wr_addr] <= job_ff.key_high;
         cre_mem[wr_addr] <= job_ff.now_time;
      end
      if (we_ls) ls_mem[wr_addr] <= wd_ls;
      st_rd_ff  <= st_mem[rd_addr];
      klo_rd_ff <= klo_mem[rd_addr];
      khi_rd_ff <= khi_mem[rd_addr];
      cre_rd_ff <= cre_mem[rd_addr];
      ls_rd_ff  <= ls_mem[rd_addr];
   end

endmodule

// ===== rtl/flow_hash_table_with_aging.sv =====
// Flow hash table with idle aging over 1024 slots, linear probing. After reset the
// block clears its slot states before it serves items. A lookup hashes the key with
// one 32x32 multiply per key word, then probes slots from the home slot onward and
// hands the result over to the response register; an expire sweep walks every slot.
// The slot memory's single read port sets one slot per cycle. Depends on fht_pkg,
// fht_front and fht_back.
module flow_hash_table_with_aging (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  fht_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output fht_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [63:0]      csr_wdata
);
   import fht_pkg::*;

   logic             job_valid, job_pop;
   job_type          job_data;
   logic [CNT_W-1:0] live_count;

   fht_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop)
   );

   fht_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_data   (job_data),
      .job_pop    (job_pop),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .live_count (live_count)
   );

   // live count never exceeds capacity
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_count <= CNT_W'(TABLE_DEPTH))
      else $error("live count above table depth");

   // sweep results carry no slot and no time
   a_sweep_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == ST_SWEPT) |->
      (rsp_data.slot_index == '0 && rsp_data.created_time == '0))
      else $error("sweep result with slot or time");

   // lookup results report no expired entries
   a_lookup_expired: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_SWEPT) |-> rsp_data.expired_entries == '0)
      else $error("lookup result with expired count");

endmodule
